@@ hw/rtl/cru_pkg.sv @@
package cru_pkg;

  localparam int unsigned VAL_W  = 32;
  localparam int unsigned SUM_W  = 64;
  localparam int unsigned QUO_W  = 17;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned ROWS   = 3;

  localparam logic [VAL_W-1:0] Q_ONE = 32'h0001_0000;
  localparam logic [15:0]      NO_TARGET = 16'hFFFF;

  localparam logic [2:0] CFG_KIND   = 3'd0;
  localparam logic [2:0] CFG_USE    = 3'd1;
  localparam logic [2:0] CFG_INV    = 3'd2;
  localparam logic [2:0] CFG_TARGET = 3'd3;
  localparam logic [2:0] CFG_TOTAL  = 3'd4;

  localparam logic [1:0] COL_TRANSLATION = 2'd3;

  typedef enum logic [1:0] {
    MODE_OWNER  = 2'd0,
    MODE_TARGET = 2'd1,
    MODE_ROT    = 2'd2
  } cru_mode_t;

  // Everything an item needs at the final mux, carried along the pipe
  typedef struct packed {
    cru_mode_t              mode;
    logic [2:0]             use_m;
    logic [2:0]             inv_m;
    logic [3:0][VAL_W-1:0]  own;
    logic [3:0][VAL_W-1:0]  tgt;
  } cru_side_t;

  function automatic logic [VAL_W-1:0] mag32(input logic [VAL_W-1:0] v);
    return v[VAL_W-1] ? (VAL_W'(0) - v) : v;
  endfunction

endpackage

@@ hw/rtl/cru_len.sv @@
module cru_len
  import cru_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  cru_side_t        in_side,
  output logic             out_valid,
  output cru_side_t        out_side,
  output logic [SUM_W-1:0] out_tsum,
  output logic [SUM_W-1:0] out_osum
);

  logic             v1_r, v2_r;
  cru_side_t        side1_r, side2_r;
  logic [SUM_W-1:0] tsq_r [ROWS];
  logic [SUM_W-1:0] osq_r [ROWS];
  logic [SUM_W-1:0] tsq_nxt [ROWS];
  logic [SUM_W-1:0] osq_nxt [ROWS];
  logic [SUM_W-1:0] tsum_r, osum_r;
  logic [VAL_W-1:0] tm [ROWS];
  logic [VAL_W-1:0] om [ROWS];

  always_comb begin
    for (int i = 0; i < ROWS; i++) begin
      tm[i] = mag32(in_side.tgt[i]);
      om[i] = mag32(in_side.own[i]);
      tsq_nxt[i] = tm[i] * tm[i];
      osq_nxt[i] = om[i] * om[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1_r <= in_side;
      tsq_r   <= tsq_nxt;
      osq_r   <= osq_nxt;
      side2_r <= side1_r;
      // squares are at most 2^62, so three of them never carry out
      tsum_r  <= tsq_r[0] + tsq_r[1] + tsq_r[2];
      osum_r  <= osq_r[0] + osq_r[1] + osq_r[2];
    end
  end

  assign out_valid = v2_r;
  assign out_side  = side2_r;
  assign out_tsum  = tsum_r;
  assign out_osum  = osum_r;

endmodule

@@ hw/rtl/cru_isqrt.sv @@
module cru_isqrt
  import cru_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  cru_side_t        in_side,
  input  logic [SUM_W-1:0] in_tsum,
  input  logic [SUM_W-1:0] in_osum,
  output logic             out_valid,
  output cru_side_t        out_side,
  output logic [VAL_W-1:0] out_tlen,
  output logic [VAL_W-1:0] out_olen
);

  localparam int unsigned STEPS = SUM_W / 2;

  // lane 0 target, lane 1 owner
  logic             vld  [STEPS+1];
  cru_side_t        side [STEPS+1];
  logic [SUM_W-1:0] rem  [STEPS+1][2];
  logic [SUM_W-1:0] root [STEPS+1][2];

  assign vld[0]     = in_valid;
  assign side[0]    = in_side;
  assign rem[0][0]  = in_tsum;
  assign rem[0][1]  = in_osum;
  assign root[0][0] = '0;
  assign root[0][1] = '0;

  for (genvar g = 0; g < STEPS; g++) begin : g_step
    localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2 * g);
    logic             vld_r;
    cru_side_t        side_r;
    logic [SUM_W-1:0] rem_r  [2];
    logic [SUM_W-1:0] root_r [2];
    logic [SUM_W-1:0] rem_nxt  [2];
    logic [SUM_W-1:0] root_nxt [2];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        if (rem[g][l] >= root[g][l] + BIT) begin
          rem_nxt[l]  = rem[g][l] - (root[g][l] + BIT);
          root_nxt[l] = (root[g][l] >> 1) + BIT;
        end else begin
          rem_nxt[l]  = rem[g][l];
          root_nxt[l] = root[g][l] >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (en) begin
        vld_r <= vld[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r <= side[g];
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
      end
    end

    assign vld[g+1]  = vld_r;
    assign side[g+1] = side_r;
    assign rem[g+1]  = rem_r;
    assign root[g+1] = root_r;
  end

  assign out_valid = vld[STEPS];
  assign out_side  = side[STEPS];
  assign out_tlen  = root[STEPS][0][VAL_W-1:0];
  assign out_olen  = root[STEPS][1][VAL_W-1:0];

endmodule

@@ hw/rtl/cru_div.sv @@
module cru_div
  import cru_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  cru_side_t                   in_side,
  input  logic [VAL_W-1:0]            in_tlen,
  input  logic [VAL_W-1:0]            in_olen,
  output logic                        out_valid,
  output cru_side_t                   out_side,
  output logic [VAL_W-1:0]            out_scale,
  output logic [ROWS-1:0][QUO_W-1:0]  out_quo,
  output logic [ROWS-1:0]             out_neg
);

  localparam int unsigned REM_W = VAL_W + 1;

  logic                       vld   [QUO_W+1];
  cru_side_t                  side  [QUO_W+1];
  logic [VAL_W-1:0]           scale [QUO_W+1];
  logic [ROWS-1:0][VAL_W-1:0] dvs   [QUO_W+1];
  logic [ROWS-1:0][QUO_W-1:0] low   [QUO_W+1];
  logic [ROWS-1:0][REM_W-1:0] rem   [QUO_W+1];
  logic [ROWS-1:0][QUO_W-1:0] quo   [QUO_W+1];
  logic [ROWS-1:0]            neg   [QUO_W+1];

  logic [VAL_W-1:0] tdiv, odiv;
  logic [VAL_W-1:0] sel_v [ROWS];
  logic [VAL_W-1:0] sel_m [ROWS];

  // Pick target or owner per row; the dividend is |v| << 16 and the
  // quotient never exceeds 2^16, so the top 31 bits start below the divisor.
  always_comb begin
    tdiv = (in_tlen == '0) ? VAL_W'(1) : in_tlen;
    odiv = (in_olen == '0) ? VAL_W'(1) : in_olen;
    for (int i = 0; i < ROWS; i++) begin
      sel_v[i]  = in_side.use_m[i] ? in_side.tgt[i] : in_side.own[i];
      sel_m[i]  = mag32(sel_v[i]);
      dvs[0][i] = in_side.use_m[i] ? tdiv : odiv;
      neg[0][i] = sel_v[i][VAL_W-1] ^ (in_side.use_m[i] & in_side.inv_m[i]);
      rem[0][i] = REM_W'(sel_m[i][VAL_W-1:QUO_W-FRAC_W]);
      low[0][i] = {sel_m[i][QUO_W-FRAC_W-1:0], FRAC_W'(0)};
      quo[0][i] = '0;
    end
  end

  assign vld[0]   = in_valid;
  assign side[0]  = in_side;
  assign scale[0] = (in_olen == '0) ? Q_ONE : in_olen;

  for (genvar g = 0; g < QUO_W; g++) begin : g_step
    logic                       vld_r;
    cru_side_t                  side_r;
    logic [VAL_W-1:0]           scale_r;
    logic [ROWS-1:0][VAL_W-1:0] dvs_r;
    logic [ROWS-1:0][QUO_W-1:0] low_r;
    logic [ROWS-1:0][REM_W-1:0] rem_r;
    logic [ROWS-1:0][QUO_W-1:0] quo_r;
    logic [ROWS-1:0]            neg_r;
    logic [ROWS-1:0][REM_W-1:0] rem_nxt;
    logic [ROWS-1:0][QUO_W-1:0] quo_nxt;
    logic [REM_W-1:0]           trial [ROWS];

    always_comb begin
      for (int i = 0; i < ROWS; i++) begin
        trial[i] = {rem[g][i][VAL_W-1:0], low[g][i][QUO_W-1]};
        if (trial[i] >= {1'b0, dvs[g][i]}) begin
          rem_nxt[i] = trial[i] - {1'b0, dvs[g][i]};
          quo_nxt[i] = {quo[g][i][QUO_W-2:0], 1'b1};
        end else begin
          rem_nxt[i] = trial[i];
          quo_nxt[i] = {quo[g][i][QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (en) begin
        vld_r <= vld[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r  <= side[g];
        scale_r <= scale[g];
        dvs_r   <= dvs[g];
        neg_r   <= neg[g];
        rem_r   <= rem_nxt;
        quo_r   <= quo_nxt;
        for (int i = 0; i < ROWS; i++) begin
          low_r[i] <= {low[g][i][QUO_W-2:0], 1'b0};
        end
      end
    end

    assign vld[g+1]   = vld_r;
    assign side[g+1]  = side_r;
    assign scale[g+1] = scale_r;
    assign dvs[g+1]   = dvs_r;
    assign low[g+1]   = low_r;
    assign rem[g+1]   = rem_r;
    assign quo[g+1]   = quo_r;
    assign neg[g+1]   = neg_r;
  end

  assign out_valid = vld[QUO_W];
  assign out_side  = side[QUO_W];
  assign out_scale = scale[QUO_W];
  assign out_quo   = quo[QUO_W];
  assign out_neg   = neg[QUO_W];

endmodule

@@ hw/rtl/cru_mul.sv @@
module cru_mul
  import cru_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  cru_side_t                   in_side,
  input  logic [VAL_W-1:0]            in_scale,
  input  logic [ROWS-1:0][QUO_W-1:0]  in_quo,
  input  logic [ROWS-1:0]             in_neg,
  output logic                        out_valid,
  output logic [3:0][VAL_W-1:0]       out_res
);

  localparam int unsigned PRD_W = QUO_W + VAL_W;
  localparam int unsigned SHR_W = PRD_W - FRAC_W;
  localparam logic [SHR_W-1:0] POS_MAX = SHR_W'(33'h0_7FFF_FFFF);
  localparam logic [SHR_W-1:0] NEG_MAX = SHR_W'(33'h0_8000_0000);

  logic                        v1_r, v2_r;
  cru_side_t                   side1_r;
  logic [ROWS-1:0][PRD_W-1:0]  prd_r;
  logic [ROWS-1:0]             neg1_r;
  logic [3:0][VAL_W-1:0]       res_r;
  logic [3:0][VAL_W-1:0]       res_nxt;
  logic [SHR_W-1:0]            shr [ROWS];
  logic [VAL_W-1:0]            sat [ROWS];

  always_comb begin
    for (int i = 0; i < ROWS; i++) begin
      shr[i] = prd_r[i][PRD_W-1:FRAC_W];
      if (!neg1_r[i]) begin
        sat[i] = (shr[i] > POS_MAX) ? 32'h7FFF_FFFF : shr[i][VAL_W-1:0];
      end else begin
        sat[i] = (shr[i] > NEG_MAX) ? 32'h8000_0000 : (VAL_W'(0) - shr[i][VAL_W-1:0]);
      end
    end
    case (side1_r.mode)
      MODE_TARGET: res_nxt = side1_r.tgt;
      MODE_ROT:    res_nxt = {side1_r.own[3], sat[2], sat[1], sat[0]};
      default:     res_nxt = side1_r.own;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1_r <= in_side;
      neg1_r  <= in_neg;
      for (int i = 0; i < ROWS; i++) begin
        prd_r[i] <= PRD_W'(in_quo[i]) * PRD_W'(in_scale);
      end
      res_r <= res_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_res   = res_r;

endmodule

@@ hw/rtl/copy_rotation_column_unit_top.sv @@
// Copy-rotation / copy-transforms constraint, one matrix column per beat.
// Registers from input accept to out_tvalid: 2 square/sum, 32 square root,
// 17 divide, 2 multiply/saturate, 1 output register. Throughput: one column
// per cycle while the skid is empty; a frozen output parks one beat in a skid.
// Reset (rst_n low, synchronous): pipe and output empty, registers to
// kind 0, use 7, invert 0, target 0xFFFF, bone total 0.
module copy_rotation_column_unit_top
  import cru_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  // configuration write port
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_wdata,
  // column beat in
  input  logic         in_tvalid,
  output logic         in_tready,
  // column_index, owner_x, owner_y, owner_z, owner_w,
  // target_x, target_y, target_z, target_w (zero padded)
  input  logic [263:0] in_tdata,
  // result beat out
  output logic         out_tvalid,
  input  logic         out_tready,
  // result_x, result_y, result_z, result_w
  output logic [127:0] out_tdata
);

  // ---------------- configuration registers ----------------
  logic        kind_r;
  logic [2:0]  use_r;
  logic [2:0]  inv_r;
  logic [15:0] target_r;
  logic [15:0] total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r   <= 1'b0;
      use_r    <= 3'b111;
      inv_r    <= 3'b000;
      target_r <= NO_TARGET;
      total_r  <= 16'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KIND:   kind_r   <= cfg_wdata[0];
        CFG_USE:    use_r    <= cfg_wdata[2:0];
        CFG_INV:    inv_r    <= cfg_wdata[2:0];
        CFG_TARGET: target_r <= cfg_wdata;
        CFG_TOTAL:  total_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- input decode ----------------
  // Settle the mode up front; the arithmetic runs regardless and the final
  // mux picks owner, target or the rebuilt column.
  logic      tgt_ok;
  cru_side_t in_side;
  logic      en;

  always_comb begin
    tgt_ok         = (target_r != NO_TARGET) && (target_r < total_r);
    in_side.use_m  = use_r;
    in_side.inv_m  = inv_r;
    for (int i = 0; i < 4; i++) begin
      in_side.own[i] = in_tdata[2 + VAL_W * i +: VAL_W];
      in_side.tgt[i] = in_tdata[2 + VAL_W * (i + 4) +: VAL_W];
    end
    if (!tgt_ok) begin
      in_side.mode = MODE_OWNER;
    end else if (kind_r) begin
      in_side.mode = MODE_TARGET;
    end else if (in_tdata[1:0] == COL_TRANSLATION) begin
      in_side.mode = MODE_OWNER;
    end else begin
      in_side.mode = MODE_ROT;
    end
  end

  // ---------------- pipeline ----------------
  logic             len_valid;
  cru_side_t        len_side;
  logic [SUM_W-1:0] len_tsum, len_osum;

  cru_len u_len (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_side   (in_side),
    .out_valid (len_valid),
    .out_side  (len_side),
    .out_tsum  (len_tsum),
    .out_osum  (len_osum)
  );

  logic             sq_valid;
  cru_side_t        sq_side;
  logic [VAL_W-1:0] sq_tlen, sq_olen;

  cru_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (len_valid),
    .in_side   (len_side),
    .in_tsum   (len_tsum),
    .in_osum   (len_osum),
    .out_valid (sq_valid),
    .out_side  (sq_side),
    .out_tlen  (sq_tlen),
    .out_olen  (sq_olen)
  );

  logic                       dv_valid;
  cru_side_t                  dv_side;
  logic [VAL_W-1:0]           dv_scale;
  logic [ROWS-1:0][QUO_W-1:0] dv_quo;
  logic [ROWS-1:0]            dv_neg;

  cru_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_valid),
    .in_side   (sq_side),
    .in_tlen   (sq_tlen),
    .in_olen   (sq_olen),
    .out_valid (dv_valid),
    .out_side  (dv_side),
    .out_scale (dv_scale),
    .out_quo   (dv_quo),
    .out_neg   (dv_neg)
  );

  logic                  pv;
  logic [3:0][VAL_W-1:0] pd;

  cru_mul u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (dv_valid),
    .in_side   (dv_side),
    .in_scale  (dv_scale),
    .in_quo    (dv_quo),
    .in_neg    (dv_neg),
    .out_valid (pv),
    .out_res   (pd)
  );

  // ---------------- output register with skid ----------------
  // The whole pipe advances while the skid is empty. When the output
  // stalls, the beat leaving the pipe that cycle lands in the skid and
  // the pipe holds on the next edge.
  logic                  out_v_r, skid_v_r;
  logic [3:0][VAL_W-1:0] out_d_r, skid_d_r;

  assign en        = !skid_v_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_tready || !out_v_r) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r  <= pv;
      end
    end else if (pv && en) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_tready || !out_v_r) begin
      out_d_r <= skid_v_r ? skid_d_r : pd;
    end else if (pv && en) begin
      skid_d_r <= pd;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

endmodule
